### rtl/npb_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npb_pkg
// Types and constants shared by the nibble pixel blitter files.
// ----------------------------------------------------------------------------
package npb_pkg;

    typedef enum logic [1:0] {
        FUNC_REG  = 2'd0,
        FUNC_CLUT = 2'd1,
        FUNC_ROM  = 2'd2,
        FUNC_NONE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        KIND_REQUEST = 2'd0,
        KIND_PIXEL   = 2'd1,
        KIND_DONE    = 2'd2,
        KIND_NONE    = 2'd3
    } t_kind;

    localparam logic [2:0] CFG_TWO_LAYER = 3'd0;
    localparam logic [2:0] CFG_ROM_LOG2  = 3'd1;
    localparam logic [2:0] CFG_ROM_BANK  = 3'd2;
    localparam logic [2:0] CFG_CLUT_BANK = 3'd3;
    localparam logic [2:0] CFG_SCROLL_Y  = 3'd4;
    localparam logic [2:0] CFG_LAYER_SEL = 3'd5;
    localparam logic [2:0] CFG_FLIP      = 3'd6;
    localparam logic [2:0] CFG_DUP_QUIRK = 3'd7;

    localparam logic [3:0] REG_SRC_LO = 4'd0;
    localparam logic [3:0] REG_SRC_HI = 4'd1;
    localparam logic [3:0] REG_DEST_X = 4'd2;
    localparam logic [3:0] REG_DEST_Y = 4'd3;
    localparam logic [3:0] REG_SIZE_X = 4'd4;
    localparam logic [3:0] REG_SIZE_Y = 4'd5;
    localparam logic [3:0] REG_DIR    = 4'd6;

    localparam logic [7:0]  TRANSPARENT = 8'hff;
    localparam logic [21:0] QUIRK_LO    = 22'h020000;
    localparam logic [21:0] QUIRK_HI    = 22'h028000;
    localparam logic [4:0]  ROM_LOG2_MIN = 5'd17;
    localparam logic [4:0]  ROM_LOG2_MAX = 5'd21;

    typedef struct packed {
        logic [1:0] func;
        logic [3:0] offset;
        logic [7:0] data;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [20:0] rom_address;
        logic        layer;
        logic [8:0]  pixel_x;
        logic [7:0]  pixel_y;
        logic [7:0]  color;
        logic [16:0] bytes_drawn;
        logic        last;
    } t_out_item;

endpackage
`default_nettype wire

### rtl/npb_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// npb_ram
// Generic RAM, one write port and two registered read ports with enable.
// ----------------------------------------------------------------------------
module npb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr_b,
    output logic [WIDTH-1:0]              o_rdata_a,
    output logic [WIDTH-1:0]              o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule
`default_nettype wire

### rtl/nibble_pixel_blitter_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nibble_pixel_blitter_top
// Rectangle blitter: register writes start a blit, rom bytes come back and
// are split into nibbles, mapped through the colour table, written as pixels.
//
//  channel | signals                                  | direction
//  in      | i_in_valid, o_in_stall, i_in_item        | into block
//  out     | o_out_valid, i_out_stall, o_out_item     | out of block
//  cfg     | i_cfg_valid, o_cfg_ready, i_cfg_index/data | into block
//
// a transaction is decoded and state updated in its accept cycle, colour
// table read issued; results then leave the result stage one per cycle
// unless i_out_stall holds them; an item yields 0 to 5 results, and a new
// transaction is accepted in the cycle the previous item's last result is loaded
// reset clears control and config; colour table is not cleared
// ----------------------------------------------------------------------------
module nibble_pixel_blitter_top #(
    parameter int CLUT_DEPTH = 2048
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_stall,
    input  wire npb_pkg::t_in_item i_in_item,
    output logic                  o_out_valid,
    input  wire logic             i_out_stall,
    output npb_pkg::t_out_item    o_out_item,
    input  wire logic             i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire logic [2:0]       i_cfg_index,
    input  wire logic [7:0]       i_cfg_data
);

    localparam int AW = $clog2(CLUT_DEPTH);

    function automatic logic [AW-1:0] f_wrap(input logic [10:0] v);
        logic [10:0] r;
        r = v;
        for (int k = 7; k >= 0; k--) begin
            if ({8'b0, r} >= (19'(CLUT_DEPTH) << k)) begin
                r = r - 11'(19'(CLUT_DEPTH) << k);
            end
        end
        return r[AW-1:0];
    endfunction

    // config
    logic       r_two_layer;
    logic [4:0] r_rom_log2;
    logic [3:0] r_rom_bank;
    logic [6:0] r_clut_bank;
    logic [7:0] r_scroll_y;
    logic [7:0] r_layer_sel;
    logic       r_flip;
    logic       r_dup_quirk;

    // blit state
    logic [15:0] r_src, n_src;
    logic [7:0]  r_dest_x, n_dest_x, r_dest_y, n_dest_y;
    logic [7:0]  r_size_x, n_size_x, r_size_y, n_size_y;
    logic [1:0]  r_dir, n_dir;
    logic        r_busy, n_busy;
    logic [20:0] r_fetch, n_fetch;
    logic [7:0]  r_cur_x, n_cur_x, r_cur_y, n_cur_y;
    logic [8:0]  r_cnt_x, n_cnt_x, r_cnt_y, n_cnt_y;
    logic [16:0] r_bytes, n_bytes;

    // result stage
    logic        r_s1_valid;
    logic        r_s1_draw, n_s1_draw;
    logic        r_s1_en0, n_s1_en0, r_s1_en1, n_s1_en1, r_s1_trans, n_s1_trans;
    logic [8:0]  r_s1_dx1, n_s1_dx1, r_s1_dx2, n_s1_dx2;
    logic [7:0]  r_s1_dy1, n_s1_dy1, r_s1_dy2, n_s1_dy2;
    logic [1:0]  r_s1_tkind, n_s1_tkind;
    logic [20:0] r_s1_taddr, n_s1_taddr;
    logic [16:0] r_s1_tbytes, n_s1_tbytes;
    logic [4:0]  r_s1_sent;

    logic        r_out_valid;
    npb_pkg::t_out_item r_out, n_out;

    logic        in_acc, has_result, load, load_tail;
    logic [4:0]  pres, pend, pick;
    logic [7:0]  c1, c2;
    logic [7:0]  ram_a_q, ram_b_q;
    logic        ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_ra, ram_rb;
    logic [4:0]  log2_sat;
    logic [20:0] rom_mask;
    logic [3:0]  bank;
    logic [21:0] next_addr;
    logic [7:0]  b;
    logic [3:0]  nib1, nib2;
    logic [7:0]  sx, sy;
    logic [20:0] start_addr;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_two_layer <= 1'b0;
            r_rom_log2  <= npb_pkg::ROM_LOG2_MAX;
            r_rom_bank  <= '0;
            r_clut_bank <= '0;
            r_scroll_y  <= '0;
            r_layer_sel <= '0;
            r_flip      <= 1'b0;
            r_dup_quirk <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                npb_pkg::CFG_TWO_LAYER: r_two_layer <= i_cfg_data[0];
                npb_pkg::CFG_ROM_LOG2:  r_rom_log2  <= i_cfg_data[4:0];
                npb_pkg::CFG_ROM_BANK:  r_rom_bank  <= i_cfg_data[3:0];
                npb_pkg::CFG_CLUT_BANK: r_clut_bank <= i_cfg_data[6:0];
                npb_pkg::CFG_SCROLL_Y:  r_scroll_y  <= i_cfg_data;
                npb_pkg::CFG_LAYER_SEL: r_layer_sel <= i_cfg_data;
                npb_pkg::CFG_FLIP:      r_flip      <= i_cfg_data[0];
                npb_pkg::CFG_DUP_QUIRK: r_dup_quirk <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // result slot selection
    assign c1 = ram_a_q;
    assign c2 = ram_b_q;

    always_comb begin
        pres[0] = r_s1_draw && r_s1_en0 && (c1 != npb_pkg::TRANSPARENT);
        pres[1] = r_s1_draw && r_s1_en0 && (c2 != npb_pkg::TRANSPARENT);
        pres[2] = r_s1_draw && r_s1_en1 && (!r_s1_trans || c1 != npb_pkg::TRANSPARENT);
        pres[3] = r_s1_draw && r_s1_en1 && (!r_s1_trans || c2 != npb_pkg::TRANSPARENT);
        pres[4] = 1'b1;
        pend = pres & ~r_s1_sent;
        if (pend[0]) begin
            pick = 5'b00001;
        end else if (pend[1]) begin
            pick = 5'b00010;
        end else if (pend[2]) begin
            pick = 5'b00100;
        end else if (pend[3]) begin
            pick = 5'b01000;
        end else begin
            pick = 5'b10000;
        end
        load      = r_s1_valid && (!r_out_valid || !i_out_stall);
        load_tail = load && pick[4];

        n_out = '0;
        case (pick)
            5'b00001: begin
                n_out.kind = npb_pkg::KIND_PIXEL;
                n_out.pixel_x = r_s1_dx1; n_out.pixel_y = r_s1_dy1; n_out.color = c1;
            end
            5'b00010: begin
                n_out.kind = npb_pkg::KIND_PIXEL;
                n_out.pixel_x = r_s1_dx2; n_out.pixel_y = r_s1_dy1; n_out.color = c2;
            end
            5'b00100: begin
                n_out.kind = npb_pkg::KIND_PIXEL; n_out.layer = 1'b1;
                n_out.pixel_x = r_s1_dx1; n_out.pixel_y = r_s1_dy2; n_out.color = c1;
            end
            5'b01000: begin
                n_out.kind = npb_pkg::KIND_PIXEL; n_out.layer = 1'b1;
                n_out.pixel_x = r_s1_dx2; n_out.pixel_y = r_s1_dy2; n_out.color = c2;
            end
            default: begin
                n_out.kind = r_s1_tkind;
                n_out.rom_address = r_s1_taddr;
                n_out.bytes_drawn = r_s1_tbytes;
                n_out.last = 1'b1;
            end
        endcase
    end

    assign o_in_stall = r_s1_valid && !load_tail;
    assign in_acc     = i_in_valid && !o_in_stall;

    // decode and state update
    always_comb begin
        log2_sat = r_rom_log2;
        if (r_rom_log2 < npb_pkg::ROM_LOG2_MIN) log2_sat = npb_pkg::ROM_LOG2_MIN;
        if (r_rom_log2 > npb_pkg::ROM_LOG2_MAX) log2_sat = npb_pkg::ROM_LOG2_MAX;
        rom_mask = 21'((22'd1 << log2_sat) - 22'd1);
        bank = r_rom_bank & 4'((5'd1 << (log2_sat - npb_pkg::ROM_LOG2_MIN)) - 5'd1);
        next_addr = {1'b0, r_fetch} + 22'd1;
        b = i_in_item.data;
        if (r_dup_quirk && next_addr >= npb_pkg::QUIRK_LO && next_addr < npb_pkg::QUIRK_HI) begin
            b = {b[3:0], b[3:0]} | b;
        end
        nib1 = r_dir[0] ? b[3:0] : b[7:4];
        nib2 = r_dir[0] ? b[7:4] : b[3:0];
        sx = r_dir[0] ? ~r_size_x : r_size_x;
        sy = r_dir[1] ? ~i_in_item.data : i_in_item.data;
        start_addr = {bank, 17'b0} + {4'b0, r_src, 1'b0};

        n_src = r_src; n_dest_x = r_dest_x; n_dest_y = r_dest_y;
        n_size_x = r_size_x; n_size_y = r_size_y; n_dir = r_dir;
        n_busy = r_busy; n_fetch = r_fetch; n_cur_x = r_cur_x; n_cur_y = r_cur_y;
        n_cnt_x = r_cnt_x; n_cnt_y = r_cnt_y; n_bytes = r_bytes;
        has_result = 1'b0;
        ram_we = 1'b0; ram_re = 1'b0;
        ram_waddr = f_wrap({r_clut_bank, i_in_item.offset});
        ram_ra = f_wrap({r_clut_bank, nib1});
        ram_rb = f_wrap({r_clut_bank, nib2});

        n_s1_draw = 1'b0;
        n_s1_en0 = !r_two_layer || r_layer_sel[0];
        n_s1_en1 = r_two_layer && r_layer_sel[1];
        n_s1_trans = r_layer_sel[3];
        n_s1_dx1 = {r_cur_x, 1'b0};
        n_s1_dx2 = {r_cur_x, 1'b1};
        n_s1_dy1 = r_two_layer ? r_cur_y : r_cur_y + r_scroll_y;
        n_s1_dy2 = r_two_layer ? r_cur_y + r_scroll_y : 8'd0;
        if (!r_flip) begin
            n_s1_dx1 = ~n_s1_dx1; n_s1_dx2 = ~n_s1_dx2;
            n_s1_dy1 = ~n_s1_dy1; n_s1_dy2 = ~n_s1_dy2;
        end
        n_s1_tkind = npb_pkg::KIND_REQUEST;
        n_s1_taddr = '0;
        n_s1_tbytes = '0;

        if (in_acc) begin
            if (i_in_item.func == npb_pkg::FUNC_REG && !r_busy) begin
                case (i_in_item.offset)
                    npb_pkg::REG_SRC_LO: n_src[7:0]  = i_in_item.data;
                    npb_pkg::REG_SRC_HI: n_src[15:8] = i_in_item.data;
                    npb_pkg::REG_DEST_X: n_dest_x = i_in_item.data;
                    npb_pkg::REG_DEST_Y: n_dest_y = i_in_item.data;
                    npb_pkg::REG_SIZE_X: n_size_x = i_in_item.data;
                    npb_pkg::REG_SIZE_Y: begin
                        n_size_y = i_in_item.data;
                        n_busy = 1'b1;
                        n_bytes = '0;
                        n_cur_x = r_dest_x + r_size_x;
                        n_cur_y = r_dest_y + i_in_item.data;
                        n_cnt_x = {1'b0, sx} + 9'd1;
                        n_cnt_y = {1'b0, sy} + 9'd1;
                        n_fetch = start_addr & rom_mask;
                        n_s1_taddr = start_addr & rom_mask;
                        has_result = 1'b1;
                    end
                    npb_pkg::REG_DIR: n_dir = i_in_item.data[1:0];
                    default: ;
                endcase
            end else if (i_in_item.func == npb_pkg::FUNC_CLUT && !r_busy) begin
                ram_we = 1'b1;
            end else if (i_in_item.func == npb_pkg::FUNC_ROM && r_busy) begin
                has_result = 1'b1;
                ram_re = 1'b1;
                n_s1_draw = 1'b1;
                n_bytes = r_bytes + 17'd1;
                n_cnt_x = r_cnt_x - 9'd1;
                n_fetch = next_addr[20:0];
                if (n_cnt_x != 9'd0) begin
                    n_cur_x = r_dir[0] ? r_cur_x + 8'd1 : r_cur_x - 8'd1;
                    n_fetch = next_addr[20:0] & rom_mask;
                    n_s1_taddr = n_fetch;
                end else begin
                    n_cnt_y = r_cnt_y - 9'd1;
                    if (n_cnt_y == 9'd0) begin
                        n_busy = 1'b0;
                        n_s1_tkind = npb_pkg::KIND_DONE;
                        n_s1_tbytes = n_bytes;
                    end else begin
                        n_cur_x = r_dest_x + r_size_x;
                        n_cnt_x = {1'b0, sx} + 9'd1;
                        n_cur_y = r_dir[1] ? r_cur_y + 8'd1 : r_cur_y - 8'd1;
                        n_fetch = next_addr[20:0] & rom_mask;
                        n_s1_taddr = n_fetch;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= '0; r_dest_x <= '0; r_dest_y <= '0; r_size_x <= '0;
            r_size_y <= '0; r_dir <= '0; r_busy <= 1'b0; r_fetch <= '0;
            r_cur_x <= '0; r_cur_y <= '0; r_cnt_x <= '0; r_cnt_y <= '0;
            r_bytes <= '0;
            r_s1_valid <= 1'b0;
            r_s1_sent <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_src <= n_src; r_dest_x <= n_dest_x; r_dest_y <= n_dest_y;
            r_size_x <= n_size_x; r_size_y <= n_size_y; r_dir <= n_dir;
            r_busy <= n_busy; r_fetch <= n_fetch; r_cur_x <= n_cur_x;
            r_cur_y <= n_cur_y; r_cnt_x <= n_cnt_x; r_cnt_y <= n_cnt_y;
            r_bytes <= n_bytes;
            if (in_acc && has_result) begin
                r_s1_valid <= 1'b1;
                r_s1_sent <= '0;
            end else if (load_tail) begin
                r_s1_valid <= 1'b0;
            end else if (load) begin
                r_s1_sent <= r_s1_sent | pick;
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && has_result) begin
            r_s1_draw <= n_s1_draw; r_s1_en0 <= n_s1_en0; r_s1_en1 <= n_s1_en1;
            r_s1_trans <= n_s1_trans; r_s1_dx1 <= n_s1_dx1; r_s1_dx2 <= n_s1_dx2;
            r_s1_dy1 <= n_s1_dy1; r_s1_dy2 <= n_s1_dy2; r_s1_tkind <= n_s1_tkind;
            r_s1_taddr <= n_s1_taddr; r_s1_tbytes <= n_s1_tbytes;
        end
        if (load) begin
            r_out <= n_out;
        end
    end

    npb_ram #(
        .WIDTH(8),
        .DEPTH(CLUT_DEPTH)
    ) u_clut (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_waddr   (ram_waddr),
        .i_wdata   (i_in_item.data),
        .i_re      (ram_re),
        .i_raddr_a (ram_ra),
        .i_raddr_b (ram_rb),
        .o_rdata_a (ram_a_q),
        .o_rdata_b (ram_b_q)
    );

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule
`default_nettype wire

### verif/tb_nibble_pixel_blitter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_nibble_pixel_blitter_top
// Self-checking bench for the nibble pixel blitter. Blits are set up through
// register writes and fed with rom bytes. A behavioral blit predictor builds
// the expected rom requests, pixel writes and done transactions. Each output
// transaction is checked against the oldest expected one, field by field.
// A short directed table runs first, then random blits across several
// configurations. The input idles at random and the output stalls at random.
// ----------------------------------------------------------------------------
module tb_nibble_pixel_blitter_top;

    localparam int SETTLE   = 16;
    localparam int LIMIT    = 800000;
    localparam int N_ITEMS  = 400;
    localparam int CLUT_DEPTH_TB = 2048;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid;
    npb_pkg::t_in_item  in_item;
    logic        out_stall;
    logic        cfg_valid;
    logic [2:0]  cfg_index;
    logic [7:0]  cfg_data;
    logic        o_in_stall;
    logic        o_out_valid;
    npb_pkg::t_out_item o_out_item;
    logic        o_cfg_ready;

    nibble_pixel_blitter_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (out_stall),
        .o_out_item  (o_out_item),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    // blit predictor: config, blit state, colour table
    logic        m_two_layer;
    logic [4:0]  m_rom_log2;
    logic [3:0]  m_rom_bank;
    logic [6:0]  m_clut_bank;
    logic [7:0]  m_scroll_y;
    logic [7:0]  m_layer_sel;
    logic        m_flip;
    logic        m_dup;
    logic [15:0] m_src;
    logic [7:0]  m_dest_x, m_dest_y, m_size_x, m_size_y;
    logic [1:0]  m_dir;
    logic        m_busy;
    logic [20:0] m_fetch;
    logic [7:0]  m_cur_x, m_cur_y;
    logic [8:0]  m_cnt_x, m_cnt_y;
    logic [16:0] m_bytes;
    logic [7:0]  m_clut [CLUT_DEPTH_TB];

    npb_pkg::t_out_item fresh_results[$];
    npb_pkg::t_out_item pending_results[$];
    npb_pkg::t_out_item typed_results[$];

    int          errors;
    int          cycles = 0;
    int          items_sent;
    int          burst_left;

    typedef struct {
        npb_pkg::t_in_item item;
        int       n_typed;
    } t_row;
    t_row        stim_rows[$];

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("tb_nibble_pixel_blitter_top: FAIL");
            $finish;
        end
    end

    task automatic report(input string what, input int unsigned got, input int unsigned exp);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, exp, cycles);
        errors++;
    endtask

    always @(posedge i_clk) begin : result_check
        npb_pkg::t_out_item e;
        if (i_rst_n && o_out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report("unexpected transaction", 32'(o_out_item.kind), 0);
            end else begin
                e = pending_results.pop_front();
                if (o_out_item.kind != e.kind) report("kind", o_out_item.kind, e.kind);
                if (o_out_item.rom_address != e.rom_address)
                    report("rom_address", o_out_item.rom_address, e.rom_address);
                if (o_out_item.layer != e.layer) report("layer", o_out_item.layer, e.layer);
                if (o_out_item.pixel_x != e.pixel_x)
                    report("pixel_x", o_out_item.pixel_x, e.pixel_x);
                if (o_out_item.pixel_y != e.pixel_y)
                    report("pixel_y", o_out_item.pixel_y, e.pixel_y);
                if (o_out_item.color != e.color) report("color", o_out_item.color, e.color);
                if (o_out_item.bytes_drawn != e.bytes_drawn)
                    report("bytes_drawn", o_out_item.bytes_drawn, e.bytes_drawn);
                if (o_out_item.last != e.last) report("last", o_out_item.last, e.last);
            end
        end
    end

    // receiver stall pattern with one long hold-off
    always @(posedge i_clk) begin : stall_gen
        int unsigned stall_cycles;
        int unsigned stall_mode;
        stall_cycles++;
        if (stall_cycles >= 600 && stall_cycles < 900) begin
            out_stall <= 1'b1;
        end else begin
            if (stall_cycles % 48 == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    function automatic npb_pkg::t_out_item mk_result(logic [1:0] kind, logic [20:0] addr,
                                            logic layer, logic [8:0] px, logic [7:0] py,
                                            logic [7:0] col, logic [16:0] nbytes);
        npb_pkg::t_out_item r;
        r.kind = kind;
        r.rom_address = addr;
        r.layer = layer;
        r.pixel_x = px;
        r.pixel_y = py;
        r.color = col;
        r.bytes_drawn = nbytes;
        r.last = 1'b0;
        return r;
    endfunction

    function automatic int rom_log2_eff();
        if (m_rom_log2 < npb_pkg::ROM_LOG2_MIN) return int'(npb_pkg::ROM_LOG2_MIN);
        if (m_rom_log2 > npb_pkg::ROM_LOG2_MAX) return int'(npb_pkg::ROM_LOG2_MAX);
        return int'(m_rom_log2);
    endfunction

    function automatic logic [7:0] colour_of(logic [3:0] nib);
        return m_clut[{m_clut_bank, nib}];
    endfunction

    task automatic push_request();
        m_fetch = m_fetch & 21'((1 << rom_log2_eff()) - 1);
        fresh_results.push_back(mk_result(npb_pkg::KIND_REQUEST, m_fetch, 0, 0, 0, 0, 0));
    endtask

    task automatic begin_blit();
        int l;
        int bank;
        l = rom_log2_eff();
        bank = m_rom_bank & ((1 << (l - 17)) - 1);
        m_busy = 1'b1;
        m_bytes = '0;
        m_cur_x = m_dest_x + m_size_x;
        m_cur_y = m_dest_y + m_size_y;
        m_cnt_x = (m_dir[0] ? {1'b0, m_size_x ^ 8'hff} : {1'b0, m_size_x}) + 9'd1;
        m_cnt_y = (m_dir[1] ? {1'b0, m_size_y ^ 8'hff} : {1'b0, m_size_y}) + 9'd1;
        m_fetch = 21'((bank << 17) + (int'(m_src) << 1));
        push_request();
    endtask

    task automatic draw_rom_byte(logic [7:0] data);
        int          nxt;
        logic [7:0]  b;
        logic [7:0]  c1, c2, y1, y2;
        logic [8:0]  x1, x2;
        nxt = int'(m_fetch) + 1;
        b = data;
        if (m_dup && nxt >= npb_pkg::QUIRK_LO && nxt < npb_pkg::QUIRK_HI)
            b = b | {b[3:0], 4'h0};
        m_fetch = 21'(nxt);
        x1 = {m_cur_x, 1'b0};
        x2 = {m_cur_x, 1'b1};
        if (m_two_layer) begin
            y1 = m_cur_y;
            y2 = m_cur_y + m_scroll_y;
        end else begin
            y1 = m_cur_y + m_scroll_y;
            y2 = 8'h00;
        end
        if (!m_flip) begin
            x1 ^= 9'h1ff;
            x2 ^= 9'h1ff;
            y1 ^= 8'hff;
            y2 ^= 8'hff;
        end
        c1 = m_dir[0] ? colour_of(b[3:0]) : colour_of(b[7:4]);
        c2 = m_dir[0] ? colour_of(b[7:4]) : colour_of(b[3:0]);
        if (!m_two_layer || m_layer_sel[0]) begin
            if (c1 != npb_pkg::TRANSPARENT)
                fresh_results.push_back(mk_result(npb_pkg::KIND_PIXEL, 0, 0, x1, y1, c1, 0));
            if (c2 != npb_pkg::TRANSPARENT)
                fresh_results.push_back(mk_result(npb_pkg::KIND_PIXEL, 0, 0, x2, y1, c2, 0));
        end
        if (m_two_layer && m_layer_sel[1]) begin
            if (!m_layer_sel[3] || c1 != npb_pkg::TRANSPARENT)
                fresh_results.push_back(mk_result(npb_pkg::KIND_PIXEL, 0, 1, x1, y2, c1, 0));
            if (!m_layer_sel[3] || c2 != npb_pkg::TRANSPARENT)
                fresh_results.push_back(mk_result(npb_pkg::KIND_PIXEL, 0, 1, x2, y2, c2, 0));
        end
        m_bytes = m_bytes + 17'd1;
        m_cnt_x = m_cnt_x - 9'd1;
        if (m_cnt_x != 0) begin
            m_cur_x = m_dir[0] ? m_cur_x + 8'd1 : m_cur_x - 8'd1;
            push_request();
        end else begin
            m_cnt_y = m_cnt_y - 9'd1;
            if (m_cnt_y == 0) begin
                m_busy = 1'b0;
                fresh_results.push_back(mk_result(npb_pkg::KIND_DONE, 0, 0, 0, 0, 0, m_bytes));
            end else begin
                m_cur_x = m_dest_x + m_size_x;
                m_cnt_x = (m_dir[0] ? {1'b0, m_size_x ^ 8'hff} : {1'b0, m_size_x}) + 9'd1;
                m_cur_y = m_dir[1] ? m_cur_y + 8'd1 : m_cur_y - 8'd1;
                push_request();
            end
        end
    endtask

    task automatic predict_blit(npb_pkg::t_in_item it);
        fresh_results.delete();
        if (it.func == npb_pkg::FUNC_REG && !m_busy) begin
            case (it.offset)
                npb_pkg::REG_SRC_LO: m_src[7:0] = it.data;
                npb_pkg::REG_SRC_HI: m_src[15:8] = it.data;
                npb_pkg::REG_DEST_X: m_dest_x = it.data;
                npb_pkg::REG_DEST_Y: m_dest_y = it.data;
                npb_pkg::REG_SIZE_X: m_size_x = it.data;
                npb_pkg::REG_SIZE_Y: begin
                    m_size_y = it.data;
                    begin_blit();
                end
                npb_pkg::REG_DIR: m_dir = it.data[1:0];
                default: ;
            endcase
        end else if (it.func == npb_pkg::FUNC_CLUT && !m_busy) begin
            m_clut[{m_clut_bank, it.offset}] = it.data;
        end else if (it.func == npb_pkg::FUNC_ROM && m_busy) begin
            draw_rom_byte(it.data);
        end
        if (fresh_results.size() > 0) fresh_results[fresh_results.size() - 1].last = 1'b1;
    endtask

    task automatic send_item(npb_pkg::t_in_item it, int n_typed, bit counts);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_blit(it);
        if (n_typed > 0) begin
            repeat (n_typed) pending_results.push_back(typed_results.pop_front());
        end else begin
            foreach (fresh_results[i]) pending_results.push_back(fresh_results[i]);
        end
        if (counts) items_sent++;
    endtask

    function automatic npb_pkg::t_in_item mk_item(logic [1:0] func, logic [3:0] off,
                                                  logic [7:0] data);
        npb_pkg::t_in_item it;
        it.func = func;
        it.offset = off;
        it.data = data;
        return it;
    endfunction

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [2:0] idx, logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            npb_pkg::CFG_TWO_LAYER: m_two_layer = value[0];
            npb_pkg::CFG_ROM_LOG2:  m_rom_log2 = value[4:0];
            npb_pkg::CFG_ROM_BANK:  m_rom_bank = value[3:0];
            npb_pkg::CFG_CLUT_BANK: m_clut_bank = value[6:0];
            npb_pkg::CFG_SCROLL_Y:  m_scroll_y = value;
            npb_pkg::CFG_LAYER_SEL: m_layer_sel = value;
            npb_pkg::CFG_FLIP:      m_flip = value[0];
            npb_pkg::CFG_DUP_QUIRK: m_dup = value[0];
            default: ;
        endcase
    endtask

    task automatic config_phase();
        int lo [8] = '{0, 17, 0, 0, 0, 0, 0, 0};
        int hi [8] = '{1, 21, 15, 127, 255, 255, 1, 1};
        int r;
        logic [7:0] v;
        wait_idle();
        for (int i = 0; i < 8; i++) begin
            r = $urandom_range(0, 3);
            v = (r == 0) ? 8'(lo[i]) : (r == 1) ? 8'(hi[i]) : 8'($urandom_range(0, 255));
            if (i == npb_pkg::CFG_LAYER_SEL && $urandom_range(0, 1)) v = v | 8'h03;
            cfg_write(3'(i), v);
        end
        cfg_valid <= 1'b0;
        for (int e = 0; e < 16; e++) begin
            v = ($urandom_range(0, 3) == 0) ? npb_pkg::TRANSPARENT : 8'($urandom_range(0, 255));
            send_item(mk_item(npb_pkg::FUNC_CLUT, 4'(e), v), 0, 1);
        end
    endtask

    task automatic noise_item();
        int r;
        r = $urandom_range(0, 2);
        if (r == 0) send_item(mk_item(npb_pkg::FUNC_NONE, 4'($urandom), 8'($urandom)), 0, 0);
        else if (r == 1)
            send_item(mk_item(npb_pkg::FUNC_CLUT, 4'($urandom), 8'($urandom)), 0, 0);
        else send_item(mk_item(npb_pkg::FUNC_REG, 4'($urandom), 8'($urandom)), 0, 0);
    endtask

    task automatic random_blit(int blit_no);
        logic [1:0] dir;
        logic [7:0] sx, sy;
        int         nbytes;
        logic [7:0] b;
        dir = 2'($urandom);
        sx = dir[0] ? 8'(255 - $urandom_range(0, 3)) : 8'($urandom_range(0, 3));
        sy = dir[1] ? 8'(255 - $urandom_range(0, 3)) : 8'($urandom_range(0, 3));
        if (blit_no % 17 == 5) sx = dir[0] ? 8'h00 : 8'hff;
        if (blit_no % 17 == 5) sy = dir[1] ? 8'hff : 8'h00;
        if ($urandom_range(0, 4) == 0)
            send_item(mk_item(npb_pkg::FUNC_ROM, 4'($urandom), 8'($urandom)), 0, 0);
        if ($urandom_range(0, 3) == 0) begin
            send_item(mk_item(npb_pkg::FUNC_REG, npb_pkg::REG_SRC_LO, 8'($urandom)), 0, 1);
            send_item(mk_item(npb_pkg::FUNC_REG, npb_pkg::REG_SRC_HI,
                              8'($urandom_range(0, 63))), 0, 1);
        end else begin
            send_item(mk_item(npb_pkg::FUNC_REG, npb_pkg::REG_SRC_LO, 8'($urandom)), 0, 1);
            send_item(mk_item(npb_pkg::FUNC_REG, npb_pkg::REG_SRC_HI, 8'($urandom)), 0, 1);
        end
        send_item(mk_item(npb_pkg::FUNC_REG, npb_pkg::REG_DEST_X, 8'($urandom)), 0, 1);
        send_item(mk_item(npb_pkg::FUNC_REG, npb_pkg::REG_DEST_Y, 8'($urandom)), 0, 1);
        send_item(mk_item(npb_pkg::FUNC_REG, npb_pkg::REG_SIZE_X, sx), 0, 1);
        send_item(mk_item(npb_pkg::FUNC_REG, npb_pkg::REG_DIR, {6'($urandom), dir}), 0, 1);
        send_item(mk_item(npb_pkg::FUNC_REG, npb_pkg::REG_SIZE_Y, sy), 0, 1);
        nbytes = int'(m_cnt_x) * int'(m_cnt_y);
        for (int i = 0; i < nbytes; i++) begin
            if ($urandom_range(0, 9) == 0) noise_item();
            b = ($urandom_range(0, 4) == 0) ? 8'hff : 8'($urandom);
            send_item(mk_item(npb_pkg::FUNC_ROM, 4'($urandom), b), 0, 1);
        end
    endtask

    initial begin
        int blits;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        errors = 0;
        items_sent = 0;
        burst_left = 0;
        m_two_layer = 0; m_rom_log2 = 5'd21; m_rom_bank = 0; m_clut_bank = 0;
        m_scroll_y = 0; m_layer_sel = 0; m_flip = 0; m_dup = 0;
        m_src = 0; m_dest_x = 0; m_dest_y = 0; m_size_x = 0; m_size_y = 0;
        m_dir = 0; m_busy = 0; m_fetch = 0;
        m_cur_x = 0; m_cur_y = 0; m_cnt_x = 0; m_cnt_y = 0; m_bytes = 0;
        i_rst_n = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed table: entry i of bank 0 holds i * 0x11, entry 15 is transparent
        for (int e = 0; e < 16; e++)
            stim_rows.push_back('{mk_item(npb_pkg::FUNC_CLUT, 4'(e), 8'(e * 8'h11)), 0});
        stim_rows.push_back('{mk_item(npb_pkg::FUNC_ROM, 4'h0, 8'h5a), 0});
        stim_rows.push_back('{mk_item(npb_pkg::FUNC_NONE, 4'hf, 8'hff), 0});
        stim_rows.push_back('{mk_item(npb_pkg::FUNC_REG, 4'hf, 8'h00), 0});
        stim_rows.push_back('{mk_item(npb_pkg::FUNC_REG, npb_pkg::REG_SIZE_Y, 8'h00), 1});
        typed_results.push_back(mk_result(npb_pkg::KIND_REQUEST, 0, 0, 0, 0, 0, 0));
        typed_results[$].last = 1'b1;
        stim_rows.push_back('{mk_item(npb_pkg::FUNC_ROM, 4'h0, 8'h12), 3});
        typed_results.push_back(mk_result(npb_pkg::KIND_PIXEL, 0, 0, 9'h1ff, 8'hff, 8'h11, 0));
        typed_results.push_back(mk_result(npb_pkg::KIND_PIXEL, 0, 0, 9'h1fe, 8'hff, 8'h22, 0));
        typed_results.push_back(mk_result(npb_pkg::KIND_DONE, 0, 0, 0, 0, 0, 17'd1));
        typed_results[$].last = 1'b1;
        stim_rows.push_back('{mk_item(npb_pkg::FUNC_REG, npb_pkg::REG_DIR, 8'hff), 0});
        stim_rows.push_back('{mk_item(npb_pkg::FUNC_REG, npb_pkg::REG_SIZE_X, 8'hff), 0});
        stim_rows.push_back('{mk_item(npb_pkg::FUNC_REG, npb_pkg::REG_SIZE_Y, 8'hfe), 0});
        stim_rows.push_back('{mk_item(npb_pkg::FUNC_REG, npb_pkg::REG_SRC_LO, 8'h11), 0});
        stim_rows.push_back('{mk_item(npb_pkg::FUNC_ROM, 4'hf, 8'hff), 0});
        stim_rows.push_back('{mk_item(npb_pkg::FUNC_ROM, 4'h0, 8'h0f), 0});
        foreach (stim_rows[i]) send_item(stim_rows[i].item, stim_rows[i].n_typed, 1);

        blits = 0;
        while (items_sent < N_ITEMS) begin
            if (blits % 6 == 0) config_phase();
            random_blit(blits);
            blits++;
        end

        wait_idle();
        if (errors == 0) begin
            $display("tb_nibble_pixel_blitter_top: PASS");
        end else begin
            $display("tb_nibble_pixel_blitter_top: FAIL");
        end
        $finish;
    end

endmodule

### files.f
rtl/npb_pkg.sv
rtl/npb_ram.sv
rtl/nibble_pixel_blitter_top.sv
verif/tb_nibble_pixel_blitter_top.sv
